// ===== hdl/plbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbb_pkg
// Shared widths, register indexes, types and helpers for the linearized
// bang-bang position controller.
// ----------------------------------------------------------------------------
package plbb_pkg;

  // Converter sample and drive widths
  localparam int SAMPLE_BITS = 16;
  localparam int DUTY_BITS   = 8;

  // Fixed-point layout
  localparam int COEF_W    = 32;
  localparam int BAND_W    = 31;
  localparam int FRAC_BITS = SAMPLE_BITS - 1;
  localparam int PROD_W    = COEF_W + SAMPLE_BITS;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHIFT_W + 1;
  localparam int EDGE_W    = COEF_W + 2;
  localparam int DIR_W     = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((COEF_W + DIR_W + DUTY_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_ZERO   = 3'd0,
    REG_COEF_ONE    = 3'd1,
    REG_COEF_TWO    = 3'd2,
    REG_COEF_THREE  = 3'd3,
    REG_COEF_FOUR   = 3'd4,
    REG_TARGET      = 3'd5,
    REG_DEAD_BAND   = 3'd6
  } reg_idx_e;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_ZERO_RST  = 32'sd4122214;
  localparam logic signed [COEF_W-1:0] COEF_ONE_RST   = -32'sd31138513;
  localparam logic signed [COEF_W-1:0] COEF_TWO_RST   = 32'sd116108165;
  localparam logic signed [COEF_W-1:0] COEF_THREE_RST = -32'sd214904340;
  localparam logic signed [COEF_W-1:0] COEF_FOUR_RST  = 32'sd154893681;
  localparam logic signed [COEF_W-1:0] TARGET_RST     = 32'sd786432;
  localparam logic [BAND_W-1:0]        DEAD_BAND_RST  = 31'd0;

  // Drive direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_HOLD    = 2'd0,
    DIR_EXTEND  = 2'd1,
    DIR_RETRACT = 2'd2
  } dir_e;

  // One item moving through the polynomial pipeline
  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [COEF_W-1:0]      acc;
  } step_t;

  // Clamp a wide signed sum into the 32-bit signed range
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = SUM_W'({1'b0, {(COEF_W-1){1'b1}}});
    min_v = -max_v - SUM_W'(1);
    if (v > max_v) begin
      sat_coef = {1'b0, {(COEF_W-1){1'b1}}};
    end else if (v < min_v) begin
      sat_coef = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      sat_coef = v[COEF_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/plbb_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbb_horner_step
// One Horner step in two register stages: multiply accumulator by sample,
// then round, rescale, add the next coefficient and saturate.
// ----------------------------------------------------------------------------
module plbb_horner_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  plbb_pkg::step_t                   step_i,
  input  logic signed [plbb_pkg::COEF_W-1:0] coef_i,
  output plbb_pkg::step_t                   step_o
);

  localparam logic signed [plbb_pkg::PROD_W-1:0] RoundConst =
    plbb_pkg::PROD_W'(1) <<< (plbb_pkg::FRAC_BITS - 1);

  // Stage A: product register
  logic                                    valid_a_q;
  logic signed [plbb_pkg::SAMPLE_BITS-1:0] x_a_q;
  logic signed [plbb_pkg::PROD_W-1:0]      prod_a_d, prod_a_q;

  // Stage B: combine and saturate
  logic signed [plbb_pkg::PROD_W-1:0]      rnd;
  logic signed [plbb_pkg::SHIFT_W-1:0]     scaled;
  logic signed [plbb_pkg::SUM_W-1:0]       sum;
  plbb_pkg::step_t                         step_d;
  logic                                    valid_b_q;
  logic signed [plbb_pkg::SAMPLE_BITS-1:0] x_b_q;
  logic signed [plbb_pkg::COEF_W-1:0]      acc_b_q;

  // Exact signed product of accumulator and sample
  assign prod_a_d = plbb_pkg::PROD_W'(step_i.acc) * plbb_pkg::PROD_W'(step_i.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= step_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_a_q    <= step_i.x;
      prod_a_q <= prod_a_d;
    end
  end

  // Round to nearest (halves up), drop the fraction, add coefficient
  always_comb begin
    rnd          = prod_a_q + RoundConst;
    scaled       = rnd[plbb_pkg::PROD_W-1:plbb_pkg::FRAC_BITS];
    sum          = plbb_pkg::SUM_W'(scaled) + plbb_pkg::SUM_W'(coef_i);
    step_d.valid = valid_a_q;
    step_d.x     = x_a_q;
    step_d.acc   = plbb_pkg::sat_coef(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_b_q <= step_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_b_q   <= step_d.x;
      acc_b_q <= step_d.acc;
    end
  end

  assign step_o.valid = valid_b_q;
  assign step_o.x     = x_b_q;
  assign step_o.acc   = acc_b_q;

endmodule

// ===== hdl/plbb_band.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbb_band
// Band compare and output register: decide drive direction and duty from the
// linearized distance and hold the result until the receiver takes it.
// ----------------------------------------------------------------------------
module plbb_band (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  plbb_pkg::step_t                     step_i,
  input  logic signed [plbb_pkg::COEF_W-1:0]  target_i,
  input  logic [plbb_pkg::BAND_W-1:0]         dead_band_i,
  output logic                                valid_o,
  output logic signed [plbb_pkg::COEF_W-1:0]  distance_o,
  output plbb_pkg::dir_e                      direction_o,
  output logic [plbb_pkg::DUTY_BITS-1:0]      duty_o
);

  logic signed [plbb_pkg::EDGE_W-1:0] lo, hi, dist_ext;
  plbb_pkg::dir_e                     dir_d;
  logic [plbb_pkg::DUTY_BITS-1:0]     duty_d;

  logic                               valid_q;
  logic signed [plbb_pkg::COEF_W-1:0] distance_q;
  plbb_pkg::dir_e                     dir_q;
  logic [plbb_pkg::DUTY_BITS-1:0]     duty_q;

  // Form band edges wide enough that they never wrap
  always_comb begin
    lo       = plbb_pkg::EDGE_W'(target_i)
             - plbb_pkg::EDGE_W'($signed({1'b0, dead_band_i}));
    hi       = plbb_pkg::EDGE_W'(target_i)
             + plbb_pkg::EDGE_W'($signed({1'b0, dead_band_i}));
    dist_ext = plbb_pkg::EDGE_W'(step_i.acc);
    dir_d    = plbb_pkg::DIR_HOLD;
    duty_d   = '0;
    if (dist_ext < lo) begin
      dir_d  = plbb_pkg::DIR_EXTEND;
      duty_d = '1;
    end else if (dist_ext > hi) begin
      dir_d  = plbb_pkg::DIR_RETRACT;
      duty_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= step_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      distance_q <= step_i.acc;
      dir_q      <= dir_d;
      duty_q     <= duty_d;
    end
  end

  assign valid_o     = valid_q;
  assign distance_o  = distance_q;
  assign direction_o = dir_q;
  assign duty_o      = duty_q;

endmodule

// ===== hdl/poly_linearized_bang_bang_position_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_linearized_bang_bang_position_top
// Linearized bang-bang position controller.
//
// Each transfer on the s_axis channel carries one signed converter sample.
// A fourth-order calibration polynomial turns it into a Q16.16 distance, and
// the distance is compared with target +/- dead band to pick the drive
// direction and duty. Each sample gives exactly one transfer on m_axis.
// Coefficients, target and dead band are written over the cfg channel, which
// is always ready; write it only while no sample is in flight.
// From input transfer to output valid, each sample passes four Horner steps
// of two stages each (multiply, then round/add/saturate) plus the band
// compare in the output register. Throughput is one sample per cycle unless
// the receiver stalls; then the whole pipeline freezes and s_axis_tready
// drops; no sample is lost or repeated. Reset clears all valid bits and
// loads the default calibration, 12 cm target and zero dead band.
// ----------------------------------------------------------------------------
module poly_linearized_bang_bang_position_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input samples
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [plbb_pkg::IN_W-1:0]          s_axis_tdata,  // [15:0] adc_sample
  // Results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [plbb_pkg::OUT_W-1:0]         m_axis_tdata,  // [31:0] distance,
                                                            // [33:32] direction,
                                                            // [41:34] duty
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [plbb_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [plbb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int NumSteps = 4;

  logic signed [plbb_pkg::COEF_W-1:0] coef_q [5];
  logic signed [plbb_pkg::COEF_W-1:0] target_q;
  logic [plbb_pkg::BAND_W-1:0]        dead_band_q;

  logic                               en;
  plbb_pkg::step_t                    chain [NumSteps+1];
  logic                               out_valid;
  logic signed [plbb_pkg::COEF_W-1:0] distance;
  plbb_pkg::dir_e                     direction;
  logic [plbb_pkg::DUTY_BITS-1:0]     duty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]   <= plbb_pkg::COEF_ZERO_RST;
      coef_q[1]   <= plbb_pkg::COEF_ONE_RST;
      coef_q[2]   <= plbb_pkg::COEF_TWO_RST;
      coef_q[3]   <= plbb_pkg::COEF_THREE_RST;
      coef_q[4]   <= plbb_pkg::COEF_FOUR_RST;
      target_q    <= plbb_pkg::TARGET_RST;
      dead_band_q <= plbb_pkg::DEAD_BAND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        plbb_pkg::REG_COEF_ZERO:  coef_q[0]   <= cfg_data_i;
        plbb_pkg::REG_COEF_ONE:   coef_q[1]   <= cfg_data_i;
        plbb_pkg::REG_COEF_TWO:   coef_q[2]   <= cfg_data_i;
        plbb_pkg::REG_COEF_THREE: coef_q[3]   <= cfg_data_i;
        plbb_pkg::REG_COEF_FOUR:  coef_q[4]   <= cfg_data_i;
        plbb_pkg::REG_TARGET:     target_q    <= cfg_data_i;
        plbb_pkg::REG_DEAD_BAND:  dead_band_q <= cfg_data_i[plbb_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished result is stuck at the output
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Seed the accumulator with the fourth-power coefficient
  assign chain[0].valid = s_axis_tvalid;
  assign chain[0].x     = s_axis_tdata[plbb_pkg::SAMPLE_BITS-1:0];
  assign chain[0].acc   = coef_q[4];

  // Horner steps, highest coefficient first
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    plbb_horner_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (chain[i]),
      .coef_i (coef_q[NumSteps-1-i]),
      .step_o (chain[i+1])
    );
  end

  plbb_band u_band (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .step_i      (chain[NumSteps]),
    .target_i    (target_q),
    .dead_band_i (dead_band_q),
    .valid_o     (out_valid),
    .distance_o  (distance),
    .direction_o (direction),
    .duty_o      (duty)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = plbb_pkg::OUT_W'({duty, direction, distance});

endmodule
